// ===== hdl/tdpb_pkg.sv =====
package tdpb_pkg;

  // Field widths of the item, result and configuration channels
  localparam int TIME_W    = 32;
  localparam int SERVICE_W = 16;
  localparam int CFG_W     = 7;

  // Saturation ceiling for finish times
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Capacity value after reset
  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(64);

  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [SERVICE_W-1:0] service_t;
  typedef logic [CFG_W-1:0]     cfg_t;

endpackage

// ===== hdl/tail_drop_packet_buffer_model_core.sv =====
// Flow: an accepted item loads its result once the finish times that end no later than its
//   arrival are retired, and once a stalled earlier result has been taken.
// A new item is taken only after the last one has loaded its result; each queued finish time
//   is retired once. The single read port of the finish-time memory sets the pace.
// Reset (rst_n low, synchronous): buffer empty, head and tail at 0, capacity 64, no result
//   pending. Memory contents are not cleared; only occupied entries are ever used.
module tail_drop_packet_buffer_model_core #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // item channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tdpb_pkg::time_t           in_arrival_time,
  input  tdpb_pkg::service_t        in_service_time,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_dropped,
  output tdpb_pkg::time_t           out_start_tick,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  tdpb_pkg::cfg_t            cfg_max_occupancy
);

  import tdpb_pkg::*;

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int OCC_W = $clog2(BUFFER_DEPTH + 1);
  localparam int CAP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUFFER_DEPTH - 1);
  localparam logic [CAP_W-1:0] CAP_MAX  = CAP_W'(BUFFER_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_CHECK
  } state_t;

  // Finish-time memory: one write port, one registered read port
  time_t            ring_mem [BUFFER_DEPTH];
  time_t            rd_data_r;
  logic [IDX_W-1:0] rd_addr;

  state_t           state_r;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r;
  logic [OCC_W-1:0] occ_r;
  time_t            last_finish_r;
  cfg_t             max_occ_r;
  time_t            arrival_r;
  service_t         service_r;

  logic             out_valid_r;
  logic             out_dropped_r;
  time_t            out_start_tick_r;

  logic             in_accept;
  logic             out_free;
  logic             retire;
  logic             done;
  logic             full;
  logic [CAP_W-1:0] cap;
  logic [CAP_W-1:0] occ_ext;
  time_t            start_w;
  logic [TIME_W:0]  sum_w;
  time_t            finish_w;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_dropped    = out_dropped_r;
  assign out_start_tick = out_start_tick_r;

  // Clamp the configured capacity to 1..BUFFER_DEPTH
  always_comb begin
    cap = CAP_W'(max_occ_r);
    if (max_occ_r == '0) begin
      cap = CAP_W'(1);
    end else if (CAP_W'(max_occ_r) > CAP_MAX) begin
      cap = CAP_MAX;
    end
  end

  assign occ_ext = CAP_W'(occ_r);
  assign full    = (occ_ext >= cap);

  // Retire the head entry while it finishes no later than the arrival
  assign retire = (state_r == S_CHECK) && (occ_r != '0) && (rd_data_r <= arrival_r);
  assign done   = (state_r == S_CHECK) && !retire && out_free;

  // Start time and saturated finish time
  assign start_w  = (occ_r == '0) ? arrival_r : last_finish_r;
  assign sum_w    = {1'b0, start_w} + {{(TIME_W + 1 - SERVICE_W){1'b0}}, service_r};
  assign finish_w = sum_w[TIME_W] ? TIME_MAX : sum_w[TIME_W-1:0];

  // Advance the head on retirement
  always_comb begin
    head_nxt = head_r;
    if (retire) begin
      head_nxt = (head_r == IDX_LAST) ? '0 : head_r + IDX_W'(1);
    end
  end

  assign rd_addr = head_nxt;

  // Memory: read the coming head, write the new finish time at the tail
  always_ff @(posedge clk) begin
    rd_data_r <= ring_mem[rd_addr];
    if (done && !full) begin
      ring_mem[tail_r] <= finish_w;
    end
  end

  // Sequencer, indices and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      max_occ_r   <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_occ_r <= cfg_max_occupancy;
      end
      // Load a new result, else clear the one just taken
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      head_r <= head_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (retire) begin
            occ_r <= occ_r - OCC_W'(1);
          end else if (done) begin
            state_r <= S_IDLE;
            if (!full) begin
              tail_r <= (tail_r == IDX_LAST) ? '0 : tail_r + IDX_W'(1);
              occ_r  <= occ_r + OCC_W'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      arrival_r <= in_arrival_time;
      service_r <= in_service_time;
    end
    if (done) begin
      out_dropped_r    <= full;
      out_start_tick_r <= full ? '0 : start_w;
      if (!full) begin
        last_finish_r <= finish_w;
      end
    end
  end

  // Occupancy never exceeds the buffer depth
  assert property (@(posedge clk) disable iff (!rst_n)
    CAP_W'(occ_r) <= CAP_MAX)
    else $error("occupancy above buffer depth");

  // An empty buffer has head and tail together
  assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0) |-> (head_r == tail_r))
    else $error("empty buffer with head and tail apart");

  // A queued item grows occupancy by one
  assert property (@(posedge clk) disable iff (!rst_n)
    (done && !full) |=> (occ_r == $past(occ_r) + OCC_W'(1)))
    else $error("queued item did not grow occupancy");

  // A dropped item reports start time zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dropped_r) |-> (out_start_tick_r == '0))
    else $error("dropped item with nonzero start time");

  // Retirement only happens while an item is in work
  assert property (@(posedge clk) disable iff (!rst_n)
    retire |=> (state_r == S_CHECK))
    else $error("retirement left the check state");

endmodule
